>>> src/npfp_pkg.sv
// npfp_pkg: shared constants, field types and the power-of-ten table for the
// nmea position field parser; no dependencies
`default_nettype none

package npfp_pkg;

   // ascii codes
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_BANG  = 8'h21;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [3:0] LAT_COMMAS_RESET = 4'd2;
   localparam logic [3:0] COMMA_COUNT_MAX  = 4'd15;

   // whole-digit rules for ddmm / dddmm
   localparam logic [2:0] WHOLE_DIGITS_SHORT = 3'd4;
   localparam logic [2:0] WHOLE_DIGITS_LONG  = 3'd5;
   localparam logic [2:0] WHOLE_COUNT_CAP    = 3'd7;

   // fixed point conversion
   localparam int FIX_SHIFT          = 24;
   localparam int MINUTES_PER_DEGREE = 60;
   localparam int MINUTE_SPAN        = 100;
   localparam int DEG_W              = 34;

   // value field captured at its closing comma
   typedef struct packed {
      logic [9:0] deg;
      logic [6:0] mm;
      logic [2:0] frac_count;
      logic       bad;
   } raw_field_type;

   // one result leaving the parser
   typedef struct packed {
      raw_field_type lat;
      raw_field_type lon;
      logic [7:0]    lat_letter;
      logic [7:0]    lon_letter;
      logic          found;
   } event_type;

   // per-stage load enables of the conversion pipeline
   typedef struct packed {
      logic mins;
      logic est;
      logic prod;
      logic fin;
   } stage_load_type;

   function automatic logic [23:0] pow_ten(input logic [2:0] n);
      logic [23:0] p;
      case (n)
         3'd0:    p = 24'd1;
         3'd1:    p = 24'd10;
         3'd2:    p = 24'd100;
         3'd3:    p = 24'd1000;
         3'd4:    p = 24'd10000;
         3'd5:    p = 24'd100000;
         3'd6:    p = 24'd1000000;
         default: p = 24'd10000000;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> src/npfp_intf.sv
// npfp channel interfaces: request bytes, position results, register writes
// depends on nothing
`default_nettype none

interface npfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       sentence_first;
   logic       sentence_last;
   modport source (output valid, char_in, sentence_first, sentence_last, input ready);
   modport sink   (input valid, char_in, sentence_first, sentence_last, output ready);
endinterface

interface npfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [33:0] lat_degrees;
   logic [7:0]  lat_hemisphere;
   logic [33:0] lon_degrees;
   logic [7:0]  lon_hemisphere;
   logic        found;
   logic        lat_bad;
   logic        lon_bad;
   modport source (output valid, lat_degrees, lat_hemisphere, lon_degrees, lon_hemisphere,
                   found, lat_bad, lon_bad, input ready);
   modport sink   (input valid, lat_degrees, lat_hemisphere, lon_degrees, lon_hemisphere,
                   found, lat_bad, lon_bad, output ready);
endinterface

interface npfp_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/npfp_parser.sv
// npfp_parser: per-byte comma counting and value field scanning, with the
// event register that starts the result pipeline; uses npfp_pkg
`default_nettype none

module npfp_parser import npfp_pkg::*; #(
   parameter int FRAC_DIGITS        = 5,
   parameter int MAX_SENTENCE_BYTES = 100,
   localparam int FRAC_W = $clog2(int'(pow_ten(3'(FRAC_DIGITS)))),
   localparam int POS_W  = $clog2(MAX_SENTENCE_BYTES + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [7:0]        char_in,
   input  logic              sentence_first,
   input  logic              sentence_last,
   input  logic [3:0]        lat_field_commas,
   output logic              in_ready,
   output logic              ev_valid,
   input  logic              ev_ready,
   output event_type         ev,
   output logic [FRAC_W-1:0] ev_lat_frac,
   output logic [FRAC_W-1:0] ev_lon_frac
);

   localparam raw_field_type RAW_RESET = '{deg: '0, mm: '0, frac_count: '0, bad: 1'b1};

   logic [3:0]        comma_count_ff, comma_count_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              after_comma_ff, after_comma_in;
   logic              emitted_ff, emitted_in;
   logic [2:0]        wcount_ff, wcount_in;
   logic              past_point_ff, past_point_in;
   logic [2:0]        fcount_ff, fcount_in;
   logic [9:0]        deg_acc_ff, deg_acc_in;
   logic [3:0]        tens_ff, tens_in;
   logic [3:0]        units_ff, units_in;
   logic [FRAC_W-1:0] frac_acc_ff, frac_acc_in;
   logic              field_err_ff, field_err_in;
   raw_field_type     held_lat_ff, held_lat_in;
   logic [FRAC_W-1:0] held_lat_frac_ff, held_lat_frac_in;
   logic [7:0]        held_lat_letter_ff, held_lat_letter_in;
   raw_field_type     held_lon_ff, held_lon_in;
   logic [FRAC_W-1:0] held_lon_frac_ff, held_lon_frac_in;

   logic              ev_valid_ff;
   event_type         ev_ff, ev_in;
   logic [FRAC_W-1:0] ev_lat_frac_ff, ev_lon_frac_ff;

   logic       fire;
   logic       fire_found;
   logic [7:0] lon_letter;
   logic [4:0] lat0, lat1, lat2, lat3, cc5;
   logic       is_digit;
   logic [3:0] digit;
   logic       ev_load;
   raw_field_type fin;

   assign lat0 = {1'b0, lat_field_commas};
   assign lat1 = lat0 + 5'd1;
   assign lat2 = lat0 + 5'd2;
   assign lat3 = lat0 + 5'd3;
   assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);
   assign digit    = 4'(char_in - CHAR_ZERO);

   always_comb begin
      comma_count_in     = comma_count_ff;
      pos_in             = pos_ff;
      after_comma_in     = after_comma_ff;
      emitted_in         = emitted_ff;
      wcount_in          = wcount_ff;
      past_point_in      = past_point_ff;
      fcount_in          = fcount_ff;
      deg_acc_in         = deg_acc_ff;
      tens_in            = tens_ff;
      units_in           = units_ff;
      frac_acc_in        = frac_acc_ff;
      field_err_in       = field_err_ff;
      held_lat_in        = held_lat_ff;
      held_lat_frac_in   = held_lat_frac_ff;
      held_lat_letter_in = held_lat_letter_ff;
      held_lon_in        = held_lon_ff;
      held_lon_frac_in   = held_lon_frac_ff;
      fire       = 1'b0;
      fire_found = 1'b0;
      lon_letter = CHAR_BANG;
      cc5        = '0;
      fin        = RAW_RESET;

      if (sentence_first) begin
         comma_count_in     = '0;
         pos_in             = '0;
         after_comma_in     = 1'b0;
         emitted_in         = 1'b0;
         wcount_in          = '0;
         past_point_in      = 1'b0;
         fcount_in          = '0;
         deg_acc_in         = '0;
         tens_in            = '0;
         units_in           = '0;
         frac_acc_in        = '0;
         field_err_in       = 1'b0;
         held_lat_in        = RAW_RESET;
         held_lat_frac_in   = '0;
         held_lat_letter_in = CHAR_BANG;
         held_lon_in        = RAW_RESET;
         held_lon_frac_in   = '0;
      end

      if (!emitted_in) begin
         if (pos_in < POS_W'(MAX_SENTENCE_BYTES)) begin
            pos_in = pos_in + POS_W'(1);
            cc5 = {1'b0, comma_count_in};
            // letter byte right after a comma
            if (after_comma_in) begin
               after_comma_in = 1'b0;
               if (cc5 == lat1) held_lat_letter_in = char_in;
               if (cc5 == lat3) begin
                  fire       = 1'b1;
                  fire_found = 1'b1;
                  lon_letter = char_in;
               end
            end
            if (!fire) begin
               if (char_in == CHAR_COMMA) begin
                  if (comma_count_in != COMMA_COUNT_MAX) begin
                     comma_count_in = comma_count_in + 4'd1;
                     after_comma_in = 1'b1;
                     cc5 = {1'b0, comma_count_in};
                     fin.deg        = deg_acc_in;
                     fin.mm         = 7'(7'({3'b0, tens_in}) * 7'd10) + 7'({3'b0, units_in});
                     fin.frac_count = fcount_in;
                     fin.bad        = field_err_in || !past_point_in ||
                                      !((wcount_in == WHOLE_DIGITS_SHORT) ||
                                        (wcount_in == WHOLE_DIGITS_LONG));
                     if (cc5 == lat1) begin
                        held_lat_in      = fin;
                        held_lat_frac_in = frac_acc_in;
                     end
                     if (cc5 == lat3) begin
                        held_lon_in      = fin;
                        held_lon_frac_in = frac_acc_in;
                     end
                     if ((cc5 == lat0) || (cc5 == lat2)) begin
                        wcount_in     = '0;
                        past_point_in = 1'b0;
                        fcount_in     = '0;
                        deg_acc_in    = '0;
                        tens_in       = '0;
                        units_in      = '0;
                        frac_acc_in   = '0;
                        field_err_in  = 1'b0;
                     end
                  end
               end else if (((cc5 == lat0) || (cc5 == lat2)) && (char_in != CHAR_SPACE)) begin
                  if (is_digit) begin
                     if (!past_point_in) begin
                        // keep the last two whole digits apart from the degrees
                        if (wcount_in < WHOLE_DIGITS_LONG) begin
                           deg_acc_in = 10'(deg_acc_in * 10'd10) + 10'({6'b0, tens_in});
                           tens_in    = units_in;
                           units_in   = digit;
                        end
                        if (wcount_in != WHOLE_COUNT_CAP) wcount_in = wcount_in + 3'd1;
                     end else if (fcount_in < 3'(FRAC_DIGITS)) begin
                        frac_acc_in = FRAC_W'(frac_acc_in * FRAC_W'(10)) + FRAC_W'(digit);
                        fcount_in   = fcount_in + 3'd1;
                     end
                  end else if (char_in == CHAR_POINT) begin
                     if (past_point_in) field_err_in = 1'b1;
                     past_point_in = 1'b1;
                  end else begin
                     field_err_in = 1'b1;
                  end
               end
            end
         end
         if (!fire && sentence_last) fire = 1'b1;
      end

      if (fire) emitted_in = 1'b1;

      ev_in.lat        = held_lat_in;
      ev_in.lon        = held_lon_in;
      ev_in.lat_letter = held_lat_letter_in;
      ev_in.lon_letter = lon_letter;
      ev_in.found      = fire_found;
   end

   assign ev_load  = !ev_valid_ff || ev_ready;
   assign in_ready = ev_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         comma_count_ff     <= '0;
         pos_ff             <= '0;
         after_comma_ff     <= 1'b0;
         emitted_ff         <= 1'b0;
         wcount_ff          <= '0;
         past_point_ff      <= 1'b0;
         fcount_ff          <= '0;
         deg_acc_ff         <= '0;
         tens_ff            <= '0;
         units_ff           <= '0;
         frac_acc_ff        <= '0;
         field_err_ff       <= 1'b0;
         held_lat_ff        <= RAW_RESET;
         held_lat_frac_ff   <= '0;
         held_lat_letter_ff <= CHAR_BANG;
         held_lon_ff        <= RAW_RESET;
         held_lon_frac_ff   <= '0;
      end else if (in_accept) begin
         comma_count_ff     <= comma_count_in;
         pos_ff             <= pos_in;
         after_comma_ff     <= after_comma_in;
         emitted_ff         <= emitted_in;
         wcount_ff          <= wcount_in;
         past_point_ff      <= past_point_in;
         fcount_ff          <= fcount_in;
         deg_acc_ff         <= deg_acc_in;
         tens_ff            <= tens_in;
         units_ff           <= units_in;
         frac_acc_ff        <= frac_acc_in;
         field_err_ff       <= field_err_in;
         held_lat_ff        <= held_lat_in;
         held_lat_frac_ff   <= held_lat_frac_in;
         held_lat_letter_ff <= held_lat_letter_in;
         held_lon_ff        <= held_lon_in;
         held_lon_frac_ff   <= held_lon_frac_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_valid_ff <= 1'b0;
      end else if (ev_load) begin
         ev_valid_ff <= in_accept && fire;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_load) begin
         ev_ff          <= ev_in;
         ev_lat_frac_ff <= held_lat_frac_in;
         ev_lon_frac_ff <= held_lon_frac_in;
      end
   end

   assign ev_valid    = ev_valid_ff;
   assign ev          = ev_ff;
   assign ev_lat_frac = ev_lat_frac_ff;
   assign ev_lon_frac = ev_lon_frac_ff;

endmodule

`default_nettype wire

>>> src/npfp_scale.sv
// npfp_scale: four-stage datapath turning a captured ddmm.mmmm field into
// degrees in units of 2^-24 by reciprocal multiply and one correction; uses npfp_pkg
`default_nettype none

module npfp_scale import npfp_pkg::*; #(
   parameter int FRAC_DIGITS = 5,
   localparam int FRAC_W = $clog2(int'(pow_ten(3'(FRAC_DIGITS))))
) (
   input  logic              clock,
   input  stage_load_type    load,
   input  raw_field_type     raw,
   input  logic [FRAC_W-1:0] frac,
   output logic [DEG_W-1:0]  degrees,
   output logic              bad
);

   localparam logic [63:0] POW_FD  = 64'(pow_ten(3'(FRAC_DIGITS)));
   localparam logic [63:0] DEN     = 64'(MINUTES_PER_DEGREE) * POW_FD;
   localparam int          MINS_W  = $clog2(64'(MINUTE_SPAN) * POW_FD);
   localparam logic [63:0] RECIP   = (64'd1 << (FIX_SHIFT + MINS_W)) / DEN;
   localparam int          RECIP_W = $clog2(RECIP + 64'd1);
   localparam int          PROD_W  = MINS_W + RECIP_W;
   localparam int          QUOT_W  =
      $clog2(((64'(MINUTE_SPAN) << FIX_SHIFT) / 64'(MINUTES_PER_DEGREE)) + 64'd1);
   localparam int          NUM_W   = MINS_W + FIX_SHIFT;

   logic [MINS_W-1:0] mins_ff, mins_in, mins2_ff, mins3_ff;
   logic [9:0]        deg1_ff, deg2_ff, deg3_ff;
   logic              bad1_ff, bad2_ff, bad3_ff;
   logic [PROD_W-1:0] prod;
   logic [QUOT_W-1:0] quot_ff, quot_in, quot3_ff, quot_fix;
   logic [NUM_W-1:0]  qd_ff, qd_in, rem;
   logic [DEG_W-1:0]  degrees_ff, degrees_in;
   logic              bad_ff;

   // minutes scaled to FRAC_DIGITS fraction digits
   assign mins_in = MINS_W'(64'(raw.mm) * POW_FD +
                            64'(frac) * 64'(pow_ten(3'(FRAC_DIGITS) - raw.frac_count)));

   // estimate is the true quotient or one below it
   assign prod    = PROD_W'(mins_ff) * PROD_W'(RECIP);
   assign quot_in = QUOT_W'(prod >> MINS_W);

   assign qd_in = NUM_W'(quot_ff) * NUM_W'(DEN);

   assign rem        = (NUM_W'(mins3_ff) << FIX_SHIFT) - qd_ff;
   assign quot_fix   = quot3_ff + QUOT_W'(rem >= NUM_W'(DEN));
   assign degrees_in = bad3_ff ? '0 : (DEG_W'(deg3_ff) << FIX_SHIFT) + DEG_W'(quot_fix);

   always_ff @(posedge clock) begin
      if (load.mins) begin
         mins_ff <= mins_in;
         deg1_ff <= raw.deg;
         bad1_ff <= raw.bad;
      end
      if (load.est) begin
         quot_ff  <= quot_in;
         mins2_ff <= mins_ff;
         deg2_ff  <= deg1_ff;
         bad2_ff  <= bad1_ff;
      end
      if (load.prod) begin
         qd_ff    <= qd_in;
         quot3_ff <= quot_ff;
         mins3_ff <= mins2_ff;
         deg3_ff  <= deg2_ff;
         bad3_ff  <= bad2_ff;
      end
      if (load.fin) begin
         degrees_ff <= degrees_in;
         bad_ff     <= bad3_ff;
      end
   end

   assign degrees = degrees_ff;
   assign bad     = bad_ff;

endmodule

`default_nettype wire

>>> src/npfp_convert.sv
// npfp_convert: valid/ready chain of the conversion pipeline, two field
// datapaths and the result register; uses npfp_pkg, npfp_scale, npfp_rsp_if
`default_nettype none

module npfp_convert import npfp_pkg::*; #(
   parameter int FRAC_DIGITS = 5,
   localparam int FRAC_W = $clog2(int'(pow_ten(3'(FRAC_DIGITS))))
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              ev_valid,
   output logic              ev_ready,
   input  event_type         ev,
   input  logic [FRAC_W-1:0] ev_lat_frac,
   input  logic [FRAC_W-1:0] ev_lon_frac,
   npfp_rsp_if.source        rsp
);

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] can_load;
   stage_load_type    load;
   event_type         meta_ff [STAGES];
   logic              lat_bad, lon_bad;
   logic [DEG_W-1:0]  lat_deg, lon_deg;

   // a stage may load when empty or when the stage after it moves
   always_comb begin
      can_load[STAGES-1] = !valid_ff[STAGES-1] || rsp.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         can_load[k] = !valid_ff[k] || can_load[k+1];
      end
   end

   assign load     = '{mins: can_load[0], est: can_load[1], prod: can_load[2],
                       fin: can_load[3]};
   assign ev_ready = can_load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (can_load[0]) valid_ff[0] <= ev_valid;
         for (int k = 1; k < STAGES; k++) begin
            if (can_load[k]) valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (can_load[0]) meta_ff[0] <= ev;
      for (int k = 1; k < STAGES; k++) begin
         if (can_load[k]) meta_ff[k] <= meta_ff[k-1];
      end
   end

   npfp_scale #(.FRAC_DIGITS(FRAC_DIGITS)) u_lat_scale (
      .clock   (clock),
      .load    (load),
      .raw     (ev.lat),
      .frac    (ev_lat_frac),
      .degrees (lat_deg),
      .bad     (lat_bad)
   );

   npfp_scale #(.FRAC_DIGITS(FRAC_DIGITS)) u_lon_scale (
      .clock   (clock),
      .load    (load),
      .raw     (ev.lon),
      .frac    (ev_lon_frac),
      .degrees (lon_deg),
      .bad     (lon_bad)
   );

   assign rsp.valid          = valid_ff[STAGES-1];
   assign rsp.lat_degrees    = lat_deg;
   assign rsp.lat_hemisphere = meta_ff[STAGES-1].lat_letter;
   assign rsp.lon_degrees    = lon_deg;
   assign rsp.lon_hemisphere = meta_ff[STAGES-1].lon_letter;
   assign rsp.found          = meta_ff[STAGES-1].found;
   assign rsp.lat_bad        = lat_bad;
   assign rsp.lon_bad        = lon_bad;

endmodule

`default_nettype wire

>>> src/nmea_position_field_parser_unit.sv
// nmea_position_field_parser_unit: top level of the latitude/longitude parser
// uses npfp_pkg, the npfp channel interfaces, npfp_parser and npfp_convert
//
//   channel  | dir | handshake      | carries
//   ---------+-----+----------------+---------------------------------------------
//   req_ch   | in  | valid / ready  | char_in, sentence_first, sentence_last
//   rsp_ch   | out | valid / ready  | lat/lon degrees, hemispheres, found, bad flags
//   csr_ch   | in  | valid / ready  | data = lat_field_commas (4 bits)
//
// one sentence byte is taken every cycle while req_ch.ready is high; all per-byte
// work is a compare, a digit multiply-add and a field capture, done between the
// input and event registers; a result transaction reaches rsp_ch through the
// event register, then minutes scaling, reciprocal multiply, back multiply and
// the correction/result register; every stage has its own valid, so bytes keep
// flowing into empty stages while a result waits on rsp_ch.ready; the input stalls
// only when the whole chain is full
// synchronous reset empties the pipeline, clears the parse state and sets the
// comma target to 2; csr_ch is always ready

`default_nettype none

module nmea_position_field_parser_unit import npfp_pkg::*; #(
   parameter int FRAC_DIGITS        = 5,
   parameter int MAX_SENTENCE_BYTES = 100
) (
   input  logic       clock,
   input  logic       reset,
   npfp_req_if.sink   req_ch,
   npfp_rsp_if.source rsp_ch,
   npfp_csr_if.sink   csr_ch
);

   localparam int FRAC_W = $clog2(int'(pow_ten(3'(FRAC_DIGITS))));

   logic [3:0]        lat_field_commas_ff;
   logic              in_accept;
   logic              in_ready;
   logic              ev_valid;
   logic              ev_ready;
   event_type         ev;
   logic [FRAC_W-1:0] ev_lat_frac;
   logic [FRAC_W-1:0] ev_lon_frac;

   // comma target register; the user must write it only while the block is idle, the block does not enforce it
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_field_commas_ff <= LAT_COMMAS_RESET;
      end else if (csr_ch.valid) begin
         lat_field_commas_ff <= csr_ch.data;
      end
   end

   // a byte transaction completes when the event register can take a result
   assign req_ch.ready = in_ready;
   assign in_accept    = req_ch.valid && in_ready;

   // comma counting, value field scan, hemisphere capture
   npfp_parser #(
      .FRAC_DIGITS        (FRAC_DIGITS),
      .MAX_SENTENCE_BYTES (MAX_SENTENCE_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .in_accept        (in_accept),
      .char_in          (req_ch.char_in),
      .sentence_first   (req_ch.sentence_first),
      .sentence_last    (req_ch.sentence_last),
      .lat_field_commas (lat_field_commas_ff),
      .in_ready         (in_ready),
      .ev_valid         (ev_valid),
      .ev_ready         (ev_ready),
      .ev               (ev),
      .ev_lat_frac      (ev_lat_frac),
      .ev_lon_frac      (ev_lon_frac)
   );

   // degrees-minutes to 2^-24 degree conversion and the result register
   npfp_convert #(.FRAC_DIGITS(FRAC_DIGITS)) u_convert (
      .clock       (clock),
      .reset       (reset),
      .ev_valid    (ev_valid),
      .ev_ready    (ev_ready),
      .ev          (ev),
      .ev_lat_frac (ev_lat_frac),
      .ev_lon_frac (ev_lon_frac),
      .rsp         (rsp_ch)
   );

endmodule

`default_nettype wire

>>> src/npfp_checker.sv
// npfp_checker: port-level assertions for nmea_position_field_parser_unit and
// the bind that attaches them; uses npfp_pkg
`default_nettype none

module npfp_checker import npfp_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DEG_W-1:0]  rsp_lat_degrees,
   input logic [DEG_W-1:0]  rsp_lon_degrees,
   input logic [7:0]        rsp_lon_hemisphere,
   input logic              rsp_found,
   input logic              rsp_lat_bad,
   input logic              rsp_lon_bad
);

   // no result transaction right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a malformed field reports zero degrees
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_lat_bad || (rsp_lat_degrees == '0)) &&
                    (!rsp_lon_bad || (rsp_lon_degrees == '0)))
      else $error("bad field with nonzero degrees");

   // an early end of sentence has no longitude letter
   a_not_found_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_lon_hemisphere == CHAR_BANG)
      else $error("found=0 result with a longitude letter");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lat_degrees) &&
                                  $stable(rsp_lon_degrees) && $stable(rsp_found))
      else $error("result changed while stalled");

endmodule

bind nmea_position_field_parser_unit npfp_checker u_npfp_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_lat_degrees    (rsp_ch.lat_degrees),
   .rsp_lon_degrees    (rsp_ch.lon_degrees),
   .rsp_lon_hemisphere (rsp_ch.lon_hemisphere),
   .rsp_found          (rsp_ch.found),
   .rsp_lat_bad        (rsp_ch.lat_bad),
   .rsp_lon_bad        (rsp_ch.lon_bad)
);

`default_nettype wire
